/* sv/apfc_pkg.sv */
// ----------------------------------------------------------------------------
// apfc_pkg
// Shared types and constants for the audio port register bank and sample
// FIFOs: bus access codes, register indexes, command codes, FIFO handshakes.
// ----------------------------------------------------------------------------
package apfc_pkg;

   localparam int DATA_W         = 32;
   localparam int SAMPLE_W       = 24;
   localparam int IDX_W          = 6;
   localparam int REG_COUNT_DEF  = 8;
   localparam int FIFO_DEPTH_DEF = 16;

   // bus access codes, the unused code behaves as no access
   localparam logic [1:0] BUS_NONE  = 2'd0;
   localparam logic [1:0] BUS_WRITE = 2'd1;
   localparam logic [1:0] BUS_READ  = 2'd2;

   // fixed register indexes
   localparam logic [IDX_W-1:0] IDX_CMD    = 6'd0;
   localparam logic [IDX_W-1:0] IDX_STATUS = 6'd1;
   localparam logic [IDX_W-1:0] IDX_LEVEL  = 6'd2;
   localparam logic [IDX_W-1:0] IDX_CFG    = 6'd3;

   // command register codes
   localparam logic [DATA_W-1:0] OP_CLR    = 32'd1;
   localparam logic [DATA_W-1:0] OP_CFG    = 32'd2;
   localparam logic [DATA_W-1:0] OP_LEVEL  = 32'd3;
   localparam logic [DATA_W-1:0] OP_START  = 32'd4;
   localparam logic [DATA_W-1:0] OP_STOP   = 32'd5;
   localparam logic [DATA_W-1:0] OP_IRQACK = 32'd6;

   typedef enum logic {
      ST_IDLE,
      ST_EXEC
   } apfc_state_type;

   typedef struct packed {
      logic clear;
      logic push;
      logic pop;
   } apfc_fifo_ctl_type;

   typedef struct packed {
      logic                empty;
      logic                full;
      logic [SAMPLE_W-1:0] head;
   } apfc_fifo_sts_type;

endpackage

/* sv/apfc_ram.sv */
// ----------------------------------------------------------------------------
// apfc_ram
// Generic single write port RAM with one registered read port.
// ----------------------------------------------------------------------------
module apfc_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* sv/apfc_fifo.sv */
// ----------------------------------------------------------------------------
// apfc_fifo
// One sample channel: pointers with a wrap flag around a RAM whose read
// port always follows the read pointer, so the head follows in the cycle after the pointer moves.
// ----------------------------------------------------------------------------
module apfc_fifo
   import apfc_pkg::*;
#(
   parameter int DEPTH = FIFO_DEPTH_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  apfc_fifo_ctl_type   ctl,
   input  logic [SAMPLE_W-1:0] push_data,
   output apfc_fifo_sts_type   sts
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

   logic [PTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic                wrapped_ff, wrapped_in;
   logic                empty;
   logic                full;
   logic                do_push;
   logic                do_pop;
   logic [SAMPLE_W-1:0] ram_q;

   assign empty   = (wr_ptr_ff == rd_ptr_ff) && !wrapped_ff;
   assign full    = (wr_ptr_ff == rd_ptr_ff) && wrapped_ff;
   assign do_push = ctl.push && !full && !ctl.clear;
   assign do_pop  = ctl.pop && !empty && !ctl.clear;

   always_comb begin
      wr_ptr_in  = wr_ptr_ff;
      rd_ptr_in  = rd_ptr_ff;
      wrapped_in = wrapped_ff;
      if (ctl.clear) begin
         wr_ptr_in  = '0;
         rd_ptr_in  = '0;
         wrapped_in = 1'b0;
      end else begin
         if (do_pop) begin
            if (rd_ptr_ff == PTR_LAST) begin
               rd_ptr_in  = '0;
               wrapped_in = 1'b0;
            end else begin
               rd_ptr_in = rd_ptr_ff + 1'b1;
            end
         end
         // a pop wrap and a push wrap never meet: that needs equal pointers that are neither empty nor full
         if (do_push) begin
            if (wr_ptr_ff == PTR_LAST) begin
               wr_ptr_in  = '0;
               wrapped_in = 1'b1;
            end else begin
               wr_ptr_in = wr_ptr_ff + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff  <= '0;
         rd_ptr_ff  <= '0;
         wrapped_ff <= 1'b0;
      end else begin
         wr_ptr_ff  <= wr_ptr_in;
         rd_ptr_ff  <= rd_ptr_in;
         wrapped_ff <= wrapped_in;
      end
   end

   apfc_ram #(
      .WIDTH (SAMPLE_W),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (do_push),
      .wr_addr (wr_ptr_ff),
      .wr_data (push_data),
      .rd_addr (rd_ptr_ff),
      .rd_data (ram_q)
   );

   assign sts.empty = empty;
   assign sts.full  = full;
   assign sts.head  = empty ? '0 : ram_q;

endmodule

/* sv/audio_port_register_and_fifo_control.sv */
// ----------------------------------------------------------------------------
// audio_port_register_and_fifo_control
// Register bank, command decode and stereo sample FIFOs of an audio port.
// ----------------------------------------------------------------------------
// Each request beat carries one bus access (none, write, read) and one sample
// request and yields exactly one response beat. Each item is registered from
// the request beat and then executed, because each sample FIFO lives in a
// RAM with a registered read port that follows the read pointer, and the
// head of the FIFO is only valid in the cycle after the pointers settle.
// The next request is taken in the cycle after execution; the response sits
// in an output register, and execution waits only while that register still
// holds a beat that has not been taken. Registers: 0 command, 1 status (bit 0
// play), 2 level, 3 cfg, the rest general storage; the left FIFO port sits at
// index REG_COUNT and the right at REG_COUNT+1. No clearing pass after reset.
module audio_port_register_and_fifo_control
   import apfc_pkg::*;
#(
   parameter int REG_COUNT  = REG_COUNT_DEF,
   parameter int FIFO_DEPTH = FIFO_DEPTH_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [1:0]                 req_cmd,
   input  logic [IDX_W-1:0]           req_reg_index,
   input  logic [DATA_W-1:0]          req_write_data,
   input  logic                       req_sample_request,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [DATA_W-1:0]          rsp_read_data,
   output logic                       rsp_playing,
   output logic                       rsp_irq,
   output logic                       rsp_tick,
   output logic signed [SAMPLE_W-1:0] rsp_left_audio,
   output logic signed [SAMPLE_W-1:0] rsp_right_audio,
   output logic                       rsp_clear_strobe,
   output logic                       rsp_cfg_strobe,
   output logic                       rsp_level_strobe,
   output logic [DATA_W-1:0]          rsp_cfg_value,
   output logic [DATA_W-1:0]          rsp_level_value
);

   localparam int REG_W = $clog2(REG_COUNT);
   localparam logic [IDX_W-1:0] IDX_REG_END = IDX_W'(REG_COUNT);
   localparam logic [IDX_W-1:0] IDX_LFIFO   = IDX_W'(REG_COUNT);
   localparam logic [IDX_W-1:0] IDX_RFIFO   = IDX_W'(REG_COUNT + 1);

   apfc_state_type state_ff, state_in;

   logic [1:0]        cmd_ff;
   logic [IDX_W-1:0]  idx_ff;
   logic [DATA_W-1:0] wdata_ff;
   logic              sreq_ff;

   logic [DATA_W-1:0] bank_ff [REG_COUNT];
   logic [DATA_W-1:0] bank_in [REG_COUNT];
   logic              play_ff, play_in;
   logic              irq_ff, irq_in;
   logic              request_ff, request_in;

   logic accept;
   logic commit;
   logic is_wr, is_rd;
   logic in_bank;
   logic tick;
   logic clr, cfg, lvl, start, stop, ack;
   logic [DATA_W-1:0] rdata;

   apfc_fifo_ctl_type left_ctl, right_ctl;
   apfc_fifo_sts_type left_sts, right_sts;

   logic                       rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0]          rsp_read_data_ff;
   logic                       rsp_playing_ff;
   logic                       rsp_irq_ff;
   logic                       rsp_tick_ff;
   logic [SAMPLE_W-1:0]        rsp_left_ff;
   logic [SAMPLE_W-1:0]        rsp_right_ff;
   logic                       rsp_clr_ff;
   logic                       rsp_cfg_ff;
   logic                       rsp_lvl_ff;
   logic [DATA_W-1:0]          rsp_cfg_value_ff;
   logic [DATA_W-1:0]          rsp_level_value_ff;

   // ---- sequencing ----
   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign commit    = (state_ff == ST_EXEC) && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (commit) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff   <= req_cmd;
         idx_ff   <= req_reg_index;
         wdata_ff <= req_write_data;
         sreq_ff  <= req_sample_request;
      end
   end

   // ---- decode ----
   assign is_wr   = (cmd_ff == BUS_WRITE);
   assign is_rd   = (cmd_ff == BUS_READ);
   assign in_bank = (idx_ff < IDX_REG_END);
   assign tick    = play_ff && request_ff;

   always_comb begin
      clr   = 1'b0;
      cfg   = 1'b0;
      lvl   = 1'b0;
      start = 1'b0;
      stop  = 1'b0;
      ack   = 1'b0;
      if (is_wr && idx_ff == IDX_CMD) begin
         unique case (wdata_ff)
            OP_CLR:    clr   = !play_ff;
            OP_CFG:    cfg   = 1'b1;
            OP_LEVEL:  lvl   = 1'b1;
            OP_START:  start = 1'b1;
            OP_STOP:   stop  = 1'b1;
            OP_IRQACK: ack   = 1'b1;
            default:   ;
         endcase
      end
   end

   always_comb begin
      rdata = '0;
      if (is_wr || is_rd) begin
         priority if (in_bank) begin
            rdata = bank_ff[idx_ff[REG_W-1:0]];
         end else if (idx_ff == IDX_LFIFO) begin
            rdata = DATA_W'(left_sts.head);
         end else if (idx_ff == IDX_RFIFO) begin
            rdata = DATA_W'(right_sts.head);
         end else begin
            rdata = '0;
         end
      end
   end

   // ---- state update ----
   always_comb begin
      bank_in = bank_ff;
      if (is_wr && in_bank) begin
         bank_in[idx_ff[REG_W-1:0]] = wdata_ff;
      end
      if (start) begin
         bank_in[IDX_STATUS[REG_W-1:0]][0] = 1'b1;
      end else if (stop) begin
         bank_in[IDX_STATUS[REG_W-1:0]][0] = 1'b0;
      end
   end

   always_comb begin
      if (!play_ff || ack || stop) begin
         irq_in = 1'b0;
      end else if (left_sts.empty && right_sts.empty) begin
         irq_in = 1'b1;
      end else begin
         irq_in = irq_ff;
      end
      request_in = play_ff && sreq_ff;
      play_in    = start ? 1'b1 : (stop ? 1'b0 : play_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < REG_COUNT; i++) begin
            bank_ff[i] <= '0;
         end
         play_ff    <= 1'b0;
         irq_ff     <= 1'b0;
         request_ff <= 1'b0;
      end else if (commit) begin
         bank_ff    <= bank_in;
         play_ff    <= play_in;
         irq_ff     <= irq_in;
         request_ff <= request_in;
      end
   end

   // ---- sample fifos ----
   always_comb begin
      left_ctl.clear  = commit && clr;
      left_ctl.pop    = commit && (tick || (is_rd && idx_ff == IDX_LFIFO));
      left_ctl.push   = commit && is_wr && (idx_ff == IDX_LFIFO);
      right_ctl.clear = commit && clr;
      right_ctl.pop   = commit && (tick || (is_rd && idx_ff == IDX_RFIFO));
      right_ctl.push  = commit && is_wr && (idx_ff == IDX_RFIFO);
   end

   apfc_fifo #(
      .DEPTH (FIFO_DEPTH)
   ) u_left_fifo (
      .clock     (clock),
      .reset     (reset),
      .ctl       (left_ctl),
      .push_data (wdata_ff[SAMPLE_W-1:0]),
      .sts       (left_sts)
   );

   apfc_fifo #(
      .DEPTH (FIFO_DEPTH)
   ) u_right_fifo (
      .clock     (clock),
      .reset     (reset),
      .ctl       (right_ctl),
      .push_data (wdata_ff[SAMPLE_W-1:0]),
      .sts       (right_sts)
   );

   // ---- response register ----
   assign rsp_valid_in = commit || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (commit) begin
         rsp_read_data_ff   <= rdata;
         rsp_playing_ff     <= play_ff;
         rsp_irq_ff         <= irq_ff;
         rsp_tick_ff        <= tick;
         rsp_left_ff        <= left_sts.head;
         rsp_right_ff       <= right_sts.head;
         rsp_clr_ff         <= clr;
         rsp_cfg_ff         <= cfg;
         rsp_lvl_ff         <= lvl;
         rsp_cfg_value_ff   <= bank_ff[IDX_CFG[REG_W-1:0]];
         rsp_level_value_ff <= bank_ff[IDX_LEVEL[REG_W-1:0]];
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_read_data    = rsp_read_data_ff;
   assign rsp_playing      = rsp_playing_ff;
   assign rsp_irq          = rsp_irq_ff;
   assign rsp_tick         = rsp_tick_ff;
   assign rsp_left_audio   = $signed(rsp_left_ff);
   assign rsp_right_audio  = $signed(rsp_right_ff);
   assign rsp_clear_strobe = rsp_clr_ff;
   assign rsp_cfg_strobe   = rsp_cfg_ff;
   assign rsp_level_strobe = rsp_lvl_ff;
   assign rsp_cfg_value    = rsp_cfg_value_ff;
   assign rsp_level_value  = rsp_level_value_ff;

   // ---- checks ----
   a_clear_empties: assert property (@(posedge clock) disable iff (reset)
      commit && clr |=> left_sts.empty && right_sts.empty)
      else $error("fifo not empty after clear command");

   a_irq_needs_play: assert property (@(posedge clock) disable iff (reset)
      $rose(irq_ff) |-> $past(play_ff))
      else $error("irq raised while stopped");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ready |=> $stable(rsp_read_data_ff) && $stable(rsp_tick_ff))
      else $error("pending response beat overwritten");

   a_one_item_in_flight: assert property (@(posedge clock) disable iff (reset)
      commit |=> state_ff == ST_IDLE && !commit)
      else $error("item executed twice");

endmodule
